>>> hw/rtl/vss_pkg.sv
// Shared types, codes and reset constants for the vehicle safety supervisor.
// No dependencies; every file of the block but vss_if imports this package.
package vss_pkg;

   // action codes
   localparam logic [2:0] ACT_UPDATE   = 3'd0;
   localparam logic [2:0] ACT_INIT     = 3'd1;
   localparam logic [2:0] ACT_ESTOP    = 3'd2;
   localparam logic [2:0] ACT_FEED     = 3'd3;
   localparam logic [2:0] ACT_SET_MODE = 3'd4;

   // mode codes
   localparam logic [2:0] MD_IDLE     = 3'd0;
   localparam logic [2:0] MD_MANUAL   = 3'd1;
   localparam logic [2:0] MD_AUTO     = 3'd2;
   localparam logic [2:0] MD_FAILSAFE = 3'd3;
   localparam logic [2:0] MD_EMERG    = 3'd4;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_CRIT_VOLT  = 3'd0;
   localparam logic [2:0] REG_SAG_DUR    = 3'd1;
   localparam logic [2:0] REG_COMM_TO    = 3'd2;
   localparam logic [2:0] REG_MIN_STEER  = 3'd3;
   localparam logic [2:0] REG_MAX_YAW    = 3'd4;
   localparam logic [2:0] REG_STALL_DUR  = 3'd5;
   localparam logic [2:0] REG_EMA_ALPHA  = 3'd6;

   localparam int CSR_ADDR_W = 5;

   // register reset values
   localparam logic [15:0] RST_CRIT_VOLT = 16'd10500;
   localparam logic [15:0] RST_SAG_DUR   = 16'd3000;
   localparam logic [15:0] RST_COMM_TO   = 16'd1000;
   localparam logic [15:0] RST_MIN_STEER = 16'd8192;
   localparam logic [14:0] RST_MAX_YAW   = 15'd500;
   localparam logic [15:0] RST_STALL_DUR = 16'd3000;
   localparam logic [8:0]  RST_EMA_ALPHA = 9'd13;

   // filter weight of one (Q8)
   localparam logic [8:0] ALPHA_ONE = 9'd256;

   // yaw wrap limits in centidegrees
   localparam logic signed [17:0] YAW_HALF = 18'sd18000;
   localparam logic signed [17:0] YAW_FULL = 18'sd36000;

   typedef struct packed {
      logic [15:0] critical_voltage_mv;
      logic [15:0] sag_duration_ms;
      logic [15:0] comm_timeout_ms;
      logic [15:0] min_steer_diff;
      logic [14:0] max_yaw_change_cdeg;
      logic [15:0] stall_limit_ms;
      logic [8:0]  ema_alpha_q8;
   } vss_cfg_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [23:0]        voltage_filter;   // Q16.8 millivolts
      logic [31:0]        sag_timer;
      logic [31:0]        comm_timer;
      logic [31:0]        stall_timer_ms;
      logic signed [15:0] reference_yaw;
      logic               estop_latch;
      logic               leak_flag;
   } vss_state_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [15:0]        voltage_mv;
      logic signed [15:0] yaw_cdeg;
      logic signed [15:0] left_drive;
      logic signed [15:0] right_drive;
      logic [15:0]        elapsed_ms;
      logic               leak_low;
      logic [2:0]         requested_mode;
   } vss_item_type;

endpackage

>>> hw/rtl/vss_if.sv
// Valid/ready channel interfaces for the supervisor: request and response beats.
// No dependencies.
interface vss_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [15:0]        voltage_mv;
   logic signed [15:0] yaw_cdeg;
   logic signed [15:0] left_drive;
   logic signed [15:0] right_drive;
   logic [15:0]        elapsed_ms;
   logic               leak_low;
   logic [2:0]         requested_mode;

   modport source (
      output valid, action, voltage_mv, yaw_cdeg, left_drive, right_drive,
             elapsed_ms, leak_low, requested_mode,
      input  ready
   );
   modport sink (
      input  valid, action, voltage_mv, yaw_cdeg, left_drive, right_drive,
             elapsed_ms, leak_low, requested_mode,
      output ready
   );
endinterface

interface vss_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode_now;
   logic        safe_ok;
   logic        leak_seen;
   logic        emergency_latched;
   logic [15:0] filtered_mv;

   modport source (
      output valid, mode_now, safe_ok, leak_seen, emergency_latched, filtered_mv,
      input  ready
   );
   modport sink (
      input  valid, mode_now, safe_ok, leak_seen, emergency_latched, filtered_mv,
      output ready
   );
endinterface

>>> hw/rtl/vss_csr.sv
// APB-style configuration registers of the supervisor.
// Depends on vss_pkg for register indexes, reset values and vss_cfg_type.
module vss_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output vss_pkg::vss_cfg_type           cfg
);
   import vss_pkg::*;

   vss_cfg_type cfg_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.critical_voltage_mv <= RST_CRIT_VOLT;
         cfg_ff.sag_duration_ms     <= RST_SAG_DUR;
         cfg_ff.comm_timeout_ms     <= RST_COMM_TO;
         cfg_ff.min_steer_diff      <= RST_MIN_STEER;
         cfg_ff.max_yaw_change_cdeg <= RST_MAX_YAW;
         cfg_ff.stall_limit_ms      <= RST_STALL_DUR;
         cfg_ff.ema_alpha_q8        <= RST_EMA_ALPHA;
      end else if (wr_en) begin
         case (reg_idx)
            REG_CRIT_VOLT: cfg_ff.critical_voltage_mv <= pwdata[15:0];
            REG_SAG_DUR:   cfg_ff.sag_duration_ms     <= pwdata[15:0];
            REG_COMM_TO:   cfg_ff.comm_timeout_ms     <= pwdata[15:0];
            REG_MIN_STEER: cfg_ff.min_steer_diff      <= pwdata[15:0];
            REG_MAX_YAW:   cfg_ff.max_yaw_change_cdeg <= pwdata[14:0];
            REG_STALL_DUR: cfg_ff.stall_limit_ms      <= pwdata[15:0];
            REG_EMA_ALPHA: cfg_ff.ema_alpha_q8        <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CRIT_VOLT: prdata = {16'd0, cfg_ff.critical_voltage_mv};
         REG_SAG_DUR:   prdata = {16'd0, cfg_ff.sag_duration_ms};
         REG_COMM_TO:   prdata = {16'd0, cfg_ff.comm_timeout_ms};
         REG_MIN_STEER: prdata = {16'd0, cfg_ff.min_steer_diff};
         REG_MAX_YAW:   prdata = {17'd0, cfg_ff.max_yaw_change_cdeg};
         REG_STALL_DUR: prdata = {16'd0, cfg_ff.stall_limit_ms};
         REG_EMA_ALPHA: prdata = {23'd0, cfg_ff.ema_alpha_q8};
         default:       prdata = 32'd0;
      endcase
   end

endmodule

>>> hw/rtl/vss_step.sv
// Next-state logic of the supervisor: one action applied to the current state.
// Depends on vss_pkg for codes, constants and the state, item and config types.
module vss_step (
   input  vss_pkg::vss_state_type cur,
   input  vss_pkg::vss_item_type  item,
   input  vss_pkg::vss_cfg_type   cfg,
   output vss_pkg::vss_state_type nxt
);
   import vss_pkg::*;

   function automatic logic [31:0] sat_add(logic [31:0] t, logic [15:0] d);
      logic [32:0] s;
      s = {1'b0, t} + {17'd0, d};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   logic [8:0]         alpha_eff;
   logic [23:0]        volt_q8;
   logic signed [24:0] filt_delta;
   logic signed [9:0]  alpha_s;
   logic signed [34:0] filt_prod;
   logic signed [34:0] filt_sum;
   logic [23:0]        filt_new;
   logic               sag_low;
   logic [31:0]        sag_new;
   logic [2:0]         mode_sag;
   logic               in_auto;
   logic [31:0]        comm_new;
   logic [2:0]         mode_comm;
   logic signed [16:0] steer;
   logic [16:0]        steer_mag;
   logic               steering;
   logic signed [17:0] yaw_d;
   logic signed [17:0] yaw_w;
   logic [17:0]        yaw_mag;
   logic               turning;
   logic [31:0]        stall_new;
   vss_state_type      upd;

   // update datapath, computed for every item and selected below
   always_comb begin
      alpha_eff  = (cfg.ema_alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha_q8;
      volt_q8    = {item.voltage_mv, 8'd0};
      // f + floor(a * (V - f) / 256) equals the weighted sum, rounded down
      filt_delta = $signed({1'b0, volt_q8}) - $signed({1'b0, cur.voltage_filter});
      alpha_s    = $signed({1'b0, alpha_eff});
      filt_prod  = alpha_s * filt_delta;
      filt_sum   = $signed({11'd0, cur.voltage_filter}) + (filt_prod >>> 8);
      filt_new   = filt_sum[23:0];

      sag_low  = filt_new < {cfg.critical_voltage_mv, 8'd0};
      sag_new  = sag_low ? sat_add(cur.sag_timer, item.elapsed_ms) : 32'd0;
      mode_sag = (sag_low && sag_new >= {16'd0, cfg.sag_duration_ms}) ? MD_FAILSAFE
                                                                       : cur.mode;

      in_auto   = mode_sag == MD_AUTO;
      comm_new  = in_auto ? sat_add(cur.comm_timer, item.elapsed_ms) : 32'd0;
      mode_comm = (in_auto && comm_new >= {16'd0, cfg.comm_timeout_ms}) ? MD_FAILSAFE
                                                                         : mode_sag;

      steer     = {item.left_drive[15], item.left_drive}
                - {item.right_drive[15], item.right_drive};
      steer_mag = steer[16] ? 17'(-steer) : 17'(steer);
      steering  = (mode_comm == MD_AUTO || mode_comm == MD_MANUAL)
               && steer_mag > {1'b0, cfg.min_steer_diff};

      // wrap the heading difference once
      yaw_d = {{2{item.yaw_cdeg[15]}}, item.yaw_cdeg}
            - {{2{cur.reference_yaw[15]}}, cur.reference_yaw};
      if (yaw_d > YAW_HALF) begin
         yaw_w = yaw_d - YAW_FULL;
      end else if (yaw_d < -YAW_HALF) begin
         yaw_w = yaw_d + YAW_FULL;
      end else begin
         yaw_w = yaw_d;
      end
      yaw_mag = yaw_w[17] ? 18'(-yaw_w) : 18'(yaw_w);
      turning = yaw_mag >= {3'd0, cfg.max_yaw_change_cdeg};

      upd                = cur;
      upd.leak_flag      = 1'b0;
      upd.voltage_filter = filt_new;
      upd.sag_timer      = sag_new;
      upd.comm_timer     = comm_new;
      upd.mode           = mode_comm;
      stall_new          = sat_add(cur.stall_timer_ms, item.elapsed_ms);
      if (steering && !turning) begin
         upd.stall_timer_ms = stall_new;
         if (stall_new >= {16'd0, cfg.stall_limit_ms}) begin
            upd.mode = MD_FAILSAFE;
         end
      end else begin
         upd.stall_timer_ms = 32'd0;
         upd.reference_yaw  = item.yaw_cdeg;
      end
   end

   always_comb begin
      nxt = cur;
      case (item.action)
         ACT_UPDATE: begin
            if (item.leak_low) begin
               nxt.leak_flag = 1'b1;
               nxt.mode      = MD_EMERG;
            end else if (cur.estop_latch) begin
               nxt.leak_flag = 1'b0;
               nxt.mode      = MD_EMERG;
            end else begin
               nxt = upd;
            end
         end
         ACT_INIT: begin
            nxt.mode           = MD_IDLE;
            nxt.voltage_filter = {item.voltage_mv, 8'd0};
            nxt.sag_timer      = 32'd0;
            nxt.comm_timer     = 32'd0;
            nxt.stall_timer_ms = 32'd0;
            nxt.reference_yaw  = item.yaw_cdeg;
            nxt.estop_latch    = 1'b0;
            nxt.leak_flag      = 1'b0;
         end
         ACT_ESTOP: begin
            nxt.estop_latch = 1'b1;
            nxt.mode        = MD_EMERG;
         end
         ACT_FEED: begin
            nxt.comm_timer = 32'd0;
         end
         ACT_SET_MODE: begin
            if (cur.mode != MD_EMERG && item.requested_mode <= MD_EMERG) begin
               nxt.mode = item.requested_mode;
            end
         end
         default: ;
      endcase
   end

endmodule

>>> hw/rtl/vehicle_safety_supervisor.sv
// Vehicle safety supervisor: mode, emergency latch, battery filter and timers.
// A request beat waits in the input register, then passes once through the
// next-state logic into the state and response registers. Throughput: one
// request per cycle unless rsp stalls; the 10x25 filter multiply sets the path.
// Reset (synchronous, active high) clears the state and loads register defaults.
// Depends on vss_pkg, vss_if, vss_csr and vss_step.
module vehicle_safety_supervisor (
   input  logic                           clock,
   input  logic                           reset,
   vss_req_if.sink                        req,
   vss_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import vss_pkg::*;

   vss_cfg_type   cfg;
   vss_state_type state_ff;
   vss_state_type state_in;
   vss_item_type  item_ff;
   logic          item_valid_ff;
   logic          out_valid_ff;
   logic [2:0]    out_mode_ff;
   logic          out_leak_ff;
   logic          out_estop_ff;
   logic [15:0]   out_filt_ff;
   logic          fire;

   vss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vss_step u_step (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg),
      .nxt  (state_in)
   );

   // process the held beat whenever the response register is free or draining
   assign fire      = item_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         item_valid_ff <= 1'b1;
      end else if (fire) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.action         <= req.action;
         item_ff.voltage_mv     <= req.voltage_mv;
         item_ff.yaw_cdeg       <= req.yaw_cdeg;
         item_ff.left_drive     <= req.left_drive;
         item_ff.right_drive    <= req.right_drive;
         item_ff.elapsed_ms     <= req.elapsed_ms;
         item_ff.leak_low       <= req.leak_low;
         item_ff.requested_mode <= req.requested_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode           <= MD_IDLE;
         state_ff.voltage_filter <= 24'd0;
         state_ff.sag_timer      <= 32'd0;
         state_ff.comm_timer     <= 32'd0;
         state_ff.stall_timer_ms <= 32'd0;
         state_ff.reference_yaw  <= 16'sd0;
         state_ff.estop_latch    <= 1'b0;
         state_ff.leak_flag      <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else if (fire) begin
         state_ff     <= state_in;
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_mode_ff  <= state_in.mode;
         out_leak_ff  <= state_in.leak_flag;
         out_estop_ff <= state_in.estop_latch;
         out_filt_ff  <= state_in.voltage_filter[23:8];
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.mode_now          = out_mode_ff;
   assign rsp.safe_ok           = !(out_mode_ff == MD_FAILSAFE
                                 || out_mode_ff == MD_EMERG);
   assign rsp.leak_seen         = out_leak_ff;
   assign rsp.emergency_latched = out_estop_ff;
   assign rsp.filtered_mv       = out_filt_ff;

   // the latch and the leak flag both pin the mode to emergency
   a_estop_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.estop_latch |-> state_ff.mode == MD_EMERG)
      else $error("estop latch set outside emergency mode");

   a_leak_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.leak_flag |-> state_ff.mode == MD_EMERG)
      else $error("leak flag set outside emergency mode");

   // a stalled response must hold back the state update
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(state_ff))
      else $error("state advanced while response stalled");

   // an empty input register always takes a beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req.ready)
      else $error("input register empty but not ready");

   // a response beat follows every processed request
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp.valid)
      else $error("processed request produced no response");

endmodule

>>> tb/sv/vehicle_safety_supervisor_tb.sv
// Self-checking testbench for vehicle_safety_supervisor: directed table, then random
// beats under several register settings, checked against an in-bench status predictor.
// Depends on vss_pkg, vss_if and the supervisor RTL.
module vehicle_safety_supervisor_tb;
   import vss_pkg::*;

   localparam logic [2:0] ACT_UNUSED  = 3'd7;
   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int RANDOM_PHASES    = 6;
   localparam int BEATS_PER_PHASE  = 240;
   localparam int CYCLE_LIMIT      = 200000;

   typedef struct packed {
      logic [2:0]  mode;
      logic        safe;
      logic        leak;
      logic        latch;
      logic [15:0] filt_mv;
   } status_type;

   typedef struct packed {
      vss_item_type it;
      logic         typed;
      status_type   want;
   } drill_row_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   vss_req_if req_ch ();
   vss_rsp_if rsp_ch ();

   vehicle_safety_supervisor uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor copy of the block
   vss_cfg_type        cfg;
   logic [2:0]         st_mode;
   logic [23:0]        st_filt;
   logic [31:0]        st_sag, st_comm, st_stall;
   logic signed [15:0] st_ref;
   logic               st_latch, st_leak;

   status_type    pending_status[$];
   drill_row_type drill[$];
   int            errors;
   int            csr_errors;
   int            cycles;
   bit            steady;
   int            last_yaw;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [31:0] add_ms(logic [31:0] t, logic [15:0] d);
      logic [32:0] s;
      s = {1'b0, t} + {17'd0, d};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic status_type next_status(vss_item_type it);
      longint unsigned a, mixed;
      int steer, turn;
      status_type s;
      case (it.action)
         ACT_UPDATE: begin
            st_leak = it.leak_low;
            if (st_latch || st_leak) begin
               st_mode = MD_EMERG;
            end else begin
               a = (cfg.ema_alpha_q8 > ALPHA_ONE) ? 64'd256 : 64'(cfg.ema_alpha_q8);
               mixed = (a * (64'(it.voltage_mv) << 8) + (64'd256 - a) * 64'(st_filt)) >> 8;
               st_filt = mixed[23:0];
               if (st_filt < {cfg.critical_voltage_mv, 8'd0}) begin
                  st_sag = add_ms(st_sag, it.elapsed_ms);
                  if (st_sag >= 32'(cfg.sag_duration_ms)) st_mode = MD_FAILSAFE;
               end else begin
                  st_sag = '0;
               end
               if (st_mode == MD_AUTO) begin
                  st_comm = add_ms(st_comm, it.elapsed_ms);
                  if (st_comm >= 32'(cfg.comm_timeout_ms)) st_mode = MD_FAILSAFE;
               end else begin
                  st_comm = '0;
               end
               steer = int'(it.left_drive) - int'(it.right_drive);
               if (steer < 0) steer = -steer;
               if ((st_mode == MD_AUTO || st_mode == MD_MANUAL) &&
                   steer > int'(cfg.min_steer_diff)) begin
                  // wrap the heading change once into +-180 degrees
                  turn = int'(it.yaw_cdeg) - int'(st_ref);
                  if (turn > int'(YAW_HALF)) turn -= int'(YAW_FULL);
                  else if (turn < -int'(YAW_HALF)) turn += int'(YAW_FULL);
                  if (turn < 0) turn = -turn;
                  if (turn >= int'(cfg.max_yaw_change_cdeg)) begin
                     st_stall = '0;
                     st_ref   = it.yaw_cdeg;
                  end else begin
                     st_stall = add_ms(st_stall, it.elapsed_ms);
                     if (st_stall >= 32'(cfg.stall_limit_ms)) st_mode = MD_FAILSAFE;
                  end
               end else begin
                  st_stall = '0;
                  st_ref   = it.yaw_cdeg;
               end
            end
         end
         ACT_INIT: begin
            st_mode  = MD_IDLE;
            st_filt  = {it.voltage_mv, 8'd0};
            st_sag   = '0;
            st_comm  = '0;
            st_stall = '0;
            st_ref   = it.yaw_cdeg;
            st_latch = 1'b0;
            st_leak  = 1'b0;
         end
         ACT_ESTOP: begin
            st_latch = 1'b1;
            st_mode  = MD_EMERG;
         end
         ACT_FEED: st_comm = '0;
         ACT_SET_MODE: begin
            if (st_mode != MD_EMERG && it.requested_mode <= MD_EMERG)
               st_mode = it.requested_mode;
         end
         default: ;
      endcase
      s.mode    = st_mode;
      s.safe    = !(st_mode == MD_FAILSAFE || st_mode == MD_EMERG);
      s.leak    = st_leak;
      s.latch   = st_latch;
      s.filt_mv = st_filt[23:8];
      return s;
   endfunction

   function automatic vss_item_type beat_of(logic [2:0] act, int volt, int yaw,
                                            int left, int right, int dt,
                                            int leak, logic [2:0] req_mode);
      vss_item_type it;
      it.action         = act;
      it.voltage_mv     = 16'(volt);
      it.yaw_cdeg       = 16'(yaw);
      it.left_drive     = 16'(left);
      it.right_drive    = 16'(right);
      it.elapsed_ms     = 16'(dt);
      it.leak_low       = 1'(leak);
      it.requested_mode = req_mode;
      return it;
   endfunction

   function automatic vss_item_type random_item();
      vss_item_type it;
      int pick, v;
      pick = $urandom_range(0, 99);
      it.action         = 3'($urandom_range(0, 7));
      it.voltage_mv     = 16'($urandom_range(0, 65535));
      it.yaw_cdeg       = 16'($urandom_range(0, 65535));
      it.left_drive     = 16'($urandom_range(0, 65535));
      it.right_drive    = 16'($urandom_range(0, 65535));
      it.elapsed_ms     = 16'($urandom_range(0, 65535));
      it.leak_low       = 1'($urandom_range(0, 1));
      it.requested_mode = 3'($urandom_range(0, 7));
      if (pick >= 91) return it;   // noise: every field at random
      if (pick < 55) it.action = ACT_UPDATE;
      else if (pick < 62) it.action = ACT_INIT;
      else if (pick < 75) it.action = ACT_SET_MODE;
      else if (pick < 88) it.action = ACT_FEED;
      else it.action = ACT_ESTOP;
      // hover around the sag threshold most of the time
      if ($urandom_range(0, 9) != 0) begin
         v = int'(cfg.critical_voltage_mv) + int'($urandom_range(0, 3000)) - 1500;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         it.voltage_mv = 16'(v);
      end
      if ($urandom_range(0, 1) != 0) begin
         last_yaw = int'($urandom_range(0, 36000)) - 18000;
      end else begin
         last_yaw = last_yaw + int'($urandom_range(0, 1200)) - 600;
         if (last_yaw > 18000) last_yaw = 18000;
         if (last_yaw < -18000) last_yaw = -18000;
      end
      it.yaw_cdeg = 16'(last_yaw);
      if ($urandom_range(0, 9) < 3)
         it.right_drive = 16'(int'(it.left_drive) + int'($urandom_range(0, 16000)) - 8000);
      if ($urandom_range(0, 9) != 0) it.elapsed_ms = 16'($urandom_range(0, 200));
      it.leak_low = ($urandom_range(0, 99) < 2);
      if ($urandom_range(0, 4) != 0)
         it.requested_mode = $urandom_range(0, 1) ? MD_AUTO : MD_MANUAL;
      return it;
   endfunction

   task automatic add_row(vss_item_type it, logic typed, status_type want);
      drill_row_type row;
      row.it    = it;
      row.typed = typed;
      row.want  = want;
      drill.push_back(row);
   endtask

   // drive one request beat; called and returns at a falling edge
   task automatic send_beat(vss_item_type it, logic typed, status_type want);
      status_type predicted;
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid          = 1'b1;
      req_ch.action         = it.action;
      req_ch.voltage_mv     = it.voltage_mv;
      req_ch.yaw_cdeg       = it.yaw_cdeg;
      req_ch.left_drive     = it.left_drive;
      req_ch.right_drive    = it.right_drive;
      req_ch.elapsed_ms     = it.elapsed_ms;
      req_ch.leak_low       = it.leak_low;
      req_ch.requested_mode = it.requested_mode;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = next_status(it);
      pending_status.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // hold the sender until every expected beat is back
   task automatic settle();
      req_ch.valid = 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_setting(logic [2:0] idx, logic [31:0] val);
      logic [31:0] kept;
      case (idx)
         REG_MAX_YAW:   kept = val & 32'h0000_7FFF;
         REG_EMA_ALPHA: kept = val & 32'h0000_01FF;
         default:       kept = val & 32'h0000_FFFF;
      endcase
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_CRIT_VOLT: cfg.critical_voltage_mv = kept[15:0];
         REG_SAG_DUR:   cfg.sag_duration_ms     = kept[15:0];
         REG_COMM_TO:   cfg.comm_timeout_ms     = kept[15:0];
         REG_MIN_STEER: cfg.min_steer_diff      = kept[15:0];
         REG_MAX_YAW:   cfg.max_yaw_change_cdeg = kept[14:0];
         REG_STALL_DUR: cfg.stall_limit_ms      = kept[15:0];
         REG_EMA_ALPHA: cfg.ema_alpha_q8        = kept[8:0];
         default: ;
      endcase
      // read it back right away
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== kept) begin
         csr_errors++;
         if (errors + csr_errors <= 10)
            $display("register %0d readback: expected %h got %h", idx, kept, prdata);
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic apply_settings(logic [15:0] crit, logic [15:0] sag, logic [15:0] comm,
                                 logic [15:0] steer, logic [14:0] yaw, logic [15:0] stall,
                                 logic [8:0] alpha);
      write_setting(REG_CRIT_VOLT, 32'(crit));
      write_setting(REG_SAG_DUR, 32'(sag));
      write_setting(REG_COMM_TO, 32'(comm));
      write_setting(REG_MIN_STEER, 32'(steer));
      write_setting(REG_MAX_YAW, 32'(yaw));
      write_setting(REG_STALL_DUR, 32'(stall));
      write_setting(REG_EMA_ALPHA, 32'(alpha));
   endtask

   // response side: random back-pressure, always ready in the steady phase
   always @(negedge clock) begin
      rsp_ch.ready = steady || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin : watch_rsp
      status_type got;
      status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.mode_now, rsp_ch.safe_ok, rsp_ch.leak_seen,
                rsp_ch.emergency_latched, rsp_ch.filtered_mv};
         if (pending_status.size() == 0) begin
            errors++;
            if (errors + csr_errors <= 10)
               $display("unexpected response beat: mode %0d filt %0d", got.mode, got.filt_mv);
         end else begin
            want = pending_status.pop_front();
            if (got !== want) begin
               errors++;
               if (errors + csr_errors <= 10) begin
                  $display("mismatch: expected mode %0d safe %b leak %b latch %b filt %0d",
                           want.mode, want.safe, want.leak, want.latch, want.filt_mv);
                  $display("          got      mode %0d safe %b leak %b latch %b filt %0d",
                           got.mode, got.safe, got.leak, got.latch, got.filt_mv);
               end
            end
         end
      end
   end

   initial begin
      steady   = 1'b0;
      last_yaw = 0;
      reset    = 1'b1;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_FEED;
      req_ch.voltage_mv = '0;
      req_ch.yaw_cdeg = '0;
      req_ch.left_drive = '0;
      req_ch.right_drive = '0;
      req_ch.elapsed_ms = '0;
      req_ch.leak_low = 1'b0;
      req_ch.requested_mode = MD_IDLE;

      cfg.critical_voltage_mv = RST_CRIT_VOLT;
      cfg.sag_duration_ms     = RST_SAG_DUR;
      cfg.comm_timeout_ms     = RST_COMM_TO;
      cfg.min_steer_diff      = RST_MIN_STEER;
      cfg.max_yaw_change_cdeg = RST_MAX_YAW;
      cfg.stall_limit_ms      = RST_STALL_DUR;
      cfg.ema_alpha_q8        = RST_EMA_ALPHA;
      st_mode  = MD_IDLE;
      st_filt  = '0;
      st_sag   = '0;
      st_comm  = '0;
      st_stall = '0;
      st_ref   = '0;
      st_latch = 1'b0;
      st_leak  = 1'b0;

      // status after reset, unknown codes, extremes of every field
      add_row(beat_of(ACT_FEED, 0, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_UNUSED, 65535, -1, -1, -1, 65535, 1, MODE_UNUSED), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MODE_UNUSED), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_INIT, 65535, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd65535});
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MD_MANUAL), 1'b1,
              {MD_MANUAL, 1'b1, 1'b0, 1'b0, 16'd65535});
      add_row(beat_of(ACT_UPDATE, 65535, 0, 32767, -32768, 0, 0, MD_IDLE), 1'b0, '0);
      add_row(beat_of(ACT_UPDATE, 65535, 18000, 32767, -32768, 100, 0, MD_IDLE), 1'b0, '0);
      // wraps to no turn at all, stall trips
      add_row(beat_of(ACT_UPDATE, 65535, -18000, 32767, -32768, 65535, 0, MD_IDLE),
              1'b0, '0);
      add_row(beat_of(ACT_UPDATE, 65535, 32767, -32768, 32767, 0, 0, MD_IDLE), 1'b0, '0);
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MD_AUTO), 1'b1,
              {MD_AUTO, 1'b1, 1'b0, 1'b0, 16'd65535});
      add_row(beat_of(ACT_UPDATE, 0, -32768, 0, 0, 65535, 0, MD_IDLE), 1'b0, '0);
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MD_AUTO), 1'b0, '0);
      add_row(beat_of(ACT_UPDATE, 12000, 0, 100, 0, 999, 0, MD_IDLE), 1'b0, '0);
      add_row(beat_of(ACT_UPDATE, 12000, 0, 100, 0, 1, 0, MD_IDLE), 1'b0, '0);
      // emergency latch blocks mode requests and updates
      add_row(beat_of(ACT_INIT, 12000, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd12000});
      add_row(beat_of(ACT_ESTOP, 0, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_EMERG, 1'b0, 1'b0, 1'b1, 16'd12000});
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MD_MANUAL), 1'b1,
              {MD_EMERG, 1'b0, 1'b0, 1'b1, 16'd12000});
      add_row(beat_of(ACT_UPDATE, 0, 0, 0, 0, 65535, 0, MD_IDLE), 1'b1,
              {MD_EMERG, 1'b0, 1'b0, 1'b1, 16'd12000});
      // leak without latch: flag clears, mode holds emergency
      add_row(beat_of(ACT_INIT, 0, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_UPDATE, 65535, 0, 0, 0, 0, 1, MD_IDLE), 1'b1,
              {MD_EMERG, 1'b0, 1'b1, 1'b0, 16'd0});
      add_row(beat_of(ACT_UPDATE, 0, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_EMERG, 1'b0, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_INIT, 0, 0, 0, 0, 0, 0, MD_IDLE), 1'b1,
              {MD_IDLE, 1'b1, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MD_EMERG), 1'b1,
              {MD_EMERG, 1'b0, 1'b0, 1'b0, 16'd0});
      add_row(beat_of(ACT_SET_MODE, 0, 0, 0, 0, 0, 0, MD_FAILSAFE), 1'b1,
              {MD_EMERG, 1'b0, 1'b0, 1'b0, 16'd0});
      // battery sag trips failsafe
      add_row(beat_of(ACT_INIT, 10000, 0, 0, 0, 0, 0, MD_IDLE), 1'b0, '0);
      add_row(beat_of(ACT_UPDATE, 10000, 0, 0, 0, 3000, 0, MD_IDLE), 1'b0, '0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (drill[i]) send_beat(drill[i].it, drill[i].typed, drill[i].want);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady = (phase == 3);
         case (phase)
            1: apply_settings('0, '0, '0, '0, '0, '0, '0);
            2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF,
                              9'h1FF);
            3: apply_settings(16'hFFFF, 16'($urandom_range(0, 3000)),
                              16'($urandom_range(0, 2000)), 16'($urandom_range(0, 20000)),
                              15'($urandom_range(0, 2000)), 16'($urandom_range(0, 3000)),
                              ALPHA_ONE);
            5: apply_settings(RST_CRIT_VOLT, RST_SAG_DUR, RST_COMM_TO, RST_MIN_STEER,
                              RST_MAX_YAW, RST_STALL_DUR, RST_EMA_ALPHA);
            default: apply_settings(16'($urandom_range(9000, 13000)),
                                    16'($urandom_range(0, 5000)),
                                    16'($urandom_range(0, 3000)),
                                    16'($urandom_range(0, 40000)),
                                    15'($urandom_range(0, 3000)),
                                    16'($urandom_range(0, 5000)),
                                    9'($urandom_range(1, 256)));
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) send_beat(random_item(), 1'b0, '0);
         settle();
      end

      repeat (8) @(posedge clock);
      if (errors == 0 && csr_errors == 0 && pending_status.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
